@@ hdl/mbcb_pkg.sv @@
package mbcb_pkg;

   localparam int COORD_BITS    = 12;
   localparam int CALC_BITS     = COORD_BITS + 2;
   localparam int CLIP_BITS     = 10;
   localparam int COLOR_BITS    = 24;
   localparam int ADDR_BITS     = 20;
   localparam int STRIDE_BITS   = COORD_BITS - 2;
   localparam int BYTE_COL_BITS = COORD_BITS - 3;

   localparam logic REQ_CMD  = 1'b0;
   localparam logic REQ_BYTE = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic signed [COORD_BITS-1:0]  dst_x1;
      logic signed [COORD_BITS-1:0]  dst_y1;
      logic signed [COORD_BITS-1:0]  dst_x2;
      logic signed [COORD_BITS-1:0]  dst_y2;
      logic [CLIP_BITS-1:0]          clip_x1;
      logic [CLIP_BITS-1:0]          clip_y1;
      logic [CLIP_BITS-1:0]          clip_x2;
      logic [CLIP_BITS-1:0]          clip_y2;
      logic [COLOR_BITS-1:0]         fg_color;
      logic [7:0]                    bitmap_byte;
   } mbcb_req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]   fb_addr;
      logic [COLOR_BITS-1:0]  pixel_color;
      logic                   last;
   } mbcb_rsp_type;

   // one decoded bitmap byte: bit i of mask is bitmap bit i (pixel 7-i)
   typedef struct packed {
      logic [7:0]                    mask;
      logic [COORD_BITS-1:0]         sy;
      logic signed [CALC_BITS-1:0]   sx0;
      logic [COLOR_BITS-1:0]         color;
   } mbcb_job_type;

endpackage

@@ hdl/mbcb_decode.sv @@
module mbcb_decode #(
   parameter int FB_WIDTH  = 600,
   parameter int FB_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mbcb_pkg::mbcb_req_type req_data,
   output logic                  job_valid,
   output mbcb_pkg::mbcb_job_type job_data,
   input  logic                  job_take
);
   import mbcb_pkg::*;

   localparam logic signed [CALC_BITS-1:0] FbWidthC  = CALC_BITS'(FB_WIDTH);
   localparam logic signed [CALC_BITS-1:0] FbHeightC = CALC_BITS'(FB_HEIGHT);
   localparam int ExtW = CALC_BITS - COORD_BITS;
   localparam int ClipExtW = CALC_BITS - CLIP_BITS;

   logic signed [CALC_BITS-1:0] origin_x_ff, origin_x_in;
   logic signed [CALC_BITS-1:0] origin_y_ff, origin_y_in;
   logic signed [CALC_BITS-1:0] win_left_ff, win_left_in;
   logic signed [CALC_BITS-1:0] win_top_ff, win_top_in;
   logic signed [CALC_BITS-1:0] win_right_ff, win_right_in;
   logic signed [CALC_BITS-1:0] win_bottom_ff, win_bottom_in;
   logic                        win_nonempty_ff, win_nonempty_in;
   logic [STRIDE_BITS-1:0]      stride_ff, stride_in;
   logic [COORD_BITS-1:0]       cur_row_ff, cur_row_in;
   logic [BYTE_COL_BITS-1:0]    cur_byte_col_ff, cur_byte_col_in;
   logic [COLOR_BITS-1:0]       draw_color_ff, draw_color_in;
   logic                        job_valid_ff, job_valid_in;
   mbcb_job_type                job_ff, job_in;

   logic                        accept;
   logic signed [CALC_BITS-1:0] dx1, dy1, dx2, dy2, cx1, cy1, cx2, cy2;
   logic signed [CALC_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
   logic signed [CALC_BITS-1:0] n_left, n_top, n_right, n_bottom, width;
   logic [CALC_BITS-1:0]        width_p7;
   logic [STRIDE_BITS-1:0]      n_stride;
   logic signed [CALC_BITS-1:0] row_w, sy_w, colb_w, sx0_w;
   logic signed [CALC_BITS-1:0] col_w [8];
   logic signed [CALC_BITS-1:0] sx_w [8];
   logic                        row_ok;
   logic [7:0]                  mask;
   logic [STRIDE_BITS-1:0]      col_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = !job_valid_ff || job_take;
   assign job_valid = job_valid_ff;
   assign job_data  = job_ff;

   // command: clipped window relative to the destination origin
   always_comb begin
      dx1 = {{ExtW{req_data.dst_x1[COORD_BITS-1]}}, req_data.dst_x1};
      dy1 = {{ExtW{req_data.dst_y1[COORD_BITS-1]}}, req_data.dst_y1};
      dx2 = {{ExtW{req_data.dst_x2[COORD_BITS-1]}}, req_data.dst_x2};
      dy2 = {{ExtW{req_data.dst_y2[COORD_BITS-1]}}, req_data.dst_y2};
      cx1 = {{ClipExtW{1'b0}}, req_data.clip_x1};
      cy1 = {{ClipExtW{1'b0}}, req_data.clip_y1};
      cx2 = {{ClipExtW{1'b0}}, req_data.clip_x2};
      cy2 = {{ClipExtW{1'b0}}, req_data.clip_y2};
      lo_x = (dx1 > cx1) ? dx1 : cx1;
      lo_y = (dy1 > cy1) ? dy1 : cy1;
      hi_x = (dx2 < cx2) ? dx2 : cx2;
      hi_y = (dy2 < cy2) ? dy2 : cy2;
      n_left   = lo_x - dx1;
      n_top    = lo_y - dy1;
      n_right  = hi_x - dx1;
      n_bottom = hi_y - dy1;
      width    = dx2 - dx1 + CALC_BITS'(1);
      width_p7 = width + CALC_BITS'(7);
      n_stride = (width > 0) ? width_p7[STRIDE_BITS+2:3] : '0;
   end

   // bitmap byte: per-pixel window and framebuffer bounds
   always_comb begin
      row_w  = {{(CALC_BITS-COORD_BITS){1'b0}}, cur_row_ff};
      sy_w   = origin_y_ff + row_w;
      colb_w = {{(CALC_BITS-COORD_BITS){1'b0}}, cur_byte_col_ff, 3'b000};
      sx0_w  = origin_x_ff + colb_w;
      row_ok = (row_w >= win_top_ff) && (row_w <= win_bottom_ff)
               && (sy_w >= 0) && (sy_w < FbHeightC);
      for (int k = 0; k < 8; k++) begin
         col_w[k] = colb_w + CALC_BITS'(k);
         sx_w[k]  = sx0_w + CALC_BITS'(k);
         mask[7-k] = req_data.bitmap_byte[7-k] && row_ok
                     && (col_w[k] >= win_left_ff) && (col_w[k] <= win_right_ff)
                     && (sx_w[k] >= 0) && (sx_w[k] < FbWidthC);
      end
      col_next = {1'b0, cur_byte_col_ff} + STRIDE_BITS'(1);
   end

   always_comb begin
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      win_left_in     = win_left_ff;
      win_top_in      = win_top_ff;
      win_right_in    = win_right_ff;
      win_bottom_in   = win_bottom_ff;
      win_nonempty_in = win_nonempty_ff;
      stride_in       = stride_ff;
      cur_row_in      = cur_row_ff;
      cur_byte_col_in = cur_byte_col_ff;
      draw_color_in   = draw_color_ff;
      job_valid_in    = job_valid_ff && !job_take;
      job_in          = job_ff;
      if (accept) begin
         if (req_data.req_type == REQ_CMD) begin
            origin_x_in     = dx1;
            origin_y_in     = dy1;
            win_left_in     = n_left;
            win_top_in      = n_top;
            win_right_in    = n_right;
            win_bottom_in   = n_bottom;
            win_nonempty_in = (n_left <= n_right) && (n_top <= n_bottom)
                              && (n_stride != '0);
            stride_in       = n_stride;
            cur_row_in      = '0;
            cur_byte_col_in = '0;
            draw_color_in   = req_data.fg_color;
         end else if (win_nonempty_ff) begin
            if (col_next >= stride_ff) begin
               cur_byte_col_in = '0;
               if (cur_row_ff != '1) begin
                  cur_row_in = cur_row_ff + COORD_BITS'(1);
               end
            end else begin
               cur_byte_col_in = col_next[BYTE_COL_BITS-1:0];
            end
            if (mask != '0) begin
               job_valid_in = 1'b1;
               job_in.mask  = mask;
               job_in.sy    = sy_w[COORD_BITS-1:0];
               job_in.sx0   = sx0_w;
               job_in.color = draw_color_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         win_left_ff     <= '0;
         win_top_ff      <= '0;
         win_right_ff    <= '0;
         win_bottom_ff   <= '0;
         win_nonempty_ff <= 1'b0;
         stride_ff       <= '0;
         cur_row_ff      <= '0;
         cur_byte_col_ff <= '0;
         draw_color_ff   <= '0;
         job_valid_ff    <= 1'b0;
      end else begin
         origin_x_ff     <= origin_x_in;
         origin_y_ff     <= origin_y_in;
         win_left_ff     <= win_left_in;
         win_top_ff      <= win_top_in;
         win_right_ff    <= win_right_in;
         win_bottom_ff   <= win_bottom_in;
         win_nonempty_ff <= win_nonempty_in;
         stride_ff       <= stride_in;
         cur_row_ff      <= cur_row_in;
         cur_byte_col_ff <= cur_byte_col_in;
         draw_color_ff   <= draw_color_in;
         job_valid_ff    <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

@@ hdl/mbcb_emit.sv @@
module mbcb_emit #(
   parameter int FB_WIDTH = 600
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  mbcb_pkg::mbcb_job_type job_data,
   output logic                   job_take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mbcb_pkg::mbcb_rsp_type rsp_data
);
   import mbcb_pkg::*;

   localparam logic [ADDR_BITS-1:0] FbWidthC = ADDR_BITS'(FB_WIDTH);

   logic                   w_valid_ff, w_valid_in;
   logic [7:0]             w_mask_ff, w_mask_in;
   logic [ADDR_BITS-1:0]   w_base_ff, w_base_in;
   logic [COLOR_BITS-1:0]  w_color_ff, w_color_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mbcb_rsp_type           rsp_ff, rsp_in;

   logic [2:0]             sel;
   logic [7:0]             mask_left;
   logic                   emit, w_done;
   logic [ADDR_BITS-1:0]   row_base;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      // highest remaining bit is the leftmost pixel still to write
      sel = '0;
      for (int i = 0; i < 8; i++) begin
         if (w_mask_ff[i]) begin
            sel = 3'(i);
         end
      end
      mask_left = w_mask_ff & ~(8'b1 << sel);
      emit      = w_valid_ff && (!rsp_valid_ff || rsp_ready);
      w_done    = emit && (mask_left == '0);
      job_take  = job_valid && (!w_valid_ff || w_done);
      row_base  = ADDR_BITS'(ADDR_BITS'(job_data.sy) * FbWidthC)
                  + {{(ADDR_BITS-CALC_BITS){job_data.sx0[CALC_BITS-1]}}, job_data.sx0};
   end

   always_comb begin
      w_valid_in   = w_valid_ff;
      w_mask_in    = w_mask_ff;
      w_base_in    = w_base_ff;
      w_color_in   = w_color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         w_mask_in           = mask_left;
         rsp_valid_in        = 1'b1;
         rsp_in.fb_addr      = w_base_ff + ADDR_BITS'(3'd7 - sel);
         rsp_in.pixel_color  = w_color_ff;
         rsp_in.last         = (mask_left == '0);
      end
      if (w_done) begin
         w_valid_in = 1'b0;
      end
      if (job_take) begin
         w_valid_in = 1'b1;
         w_mask_in  = job_data.mask;
         w_base_in  = row_base;
         w_color_in = job_data.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_mask_ff  <= w_mask_in;
      w_base_ff  <= w_base_in;
      w_color_ff <= w_color_in;
      rsp_ff     <= rsp_in;
   end

endmodule

@@ hdl/mono_bitmap_clip_blit_unit.sv @@
// The first write of a bitmap byte passes the job, serializer and output registers. Throughput: one
// write per cycle while the output is not stalled; a byte gives one write per visible set pixel (1..8),
// a byte with none, or a command, gives none, and the decoder can take the next byte while the serializer
// still writes the last one. The 8-to-1 pixel serializer in front of the output register sets the rate.
// Reset (synchronous, active high) clears the blit state: no blit active, position and color zero.
module mono_bitmap_clip_blit_unit #(
   parameter int FB_WIDTH  = 600,
   parameter int FB_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mbcb_pkg::mbcb_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mbcb_pkg::mbcb_rsp_type rsp_data
);
   import mbcb_pkg::*;

   logic         job_valid;
   logic         job_take;
   mbcb_job_type job_data;

   mbcb_decode #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_take  (job_take)
   );

   mbcb_emit #(
      .FB_WIDTH (FB_WIDTH)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_take  (job_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/blit_check_pkg.sv @@
package blit_check_pkg;

   import mbcb_pkg::*;

   localparam int FRAME_WIDTH  = 600;
   localparam int FRAME_HEIGHT = 1024;
   localparam int MAX_ROW      = (1 << COORD_BITS) - 1;
   localparam int REPORT_LIMIT = 10;

   // Tracks the blit position and holds the framebuffer writes still owed by the block.
   class blit_scoreboard;
      int                     origin_x;
      int                     origin_y;
      int                     win_left;
      int                     win_top;
      int                     win_right;
      int                     win_bottom;
      bit                     win_nonempty;
      int                     row_stride;
      int                     cur_row;
      int                     cur_byte_col;
      logic [COLOR_BITS-1:0]  draw_color;
      mbcb_rsp_type           pending_writes[$];
      int                     failures;

      function new();
         origin_x     = 0;
         origin_y     = 0;
         win_left     = 0;
         win_top      = 0;
         win_right    = 0;
         win_bottom   = 0;
         win_nonempty = 1'b0;
         row_stride   = 0;
         cur_row      = 0;
         cur_byte_col = 0;
         draw_color   = '0;
         failures     = 0;
      endfunction

      function int coord(logic [COORD_BITS-1:0] v);
         return {{(32-COORD_BITS){v[COORD_BITS-1]}}, v};
      endfunction

      function void log_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      // Returns 1 when the transaction does something (a command, or a byte of an active blit).
      function bit note_request(mbcb_req_type r);
         int dx1, dy1, dx2, dy2, cx1, cy1, cx2, cy2;
         int span, col, sx, sy, addr, found;
         mbcb_rsp_type w;
         if (r.req_type == REQ_CMD) begin
            dx1 = coord(r.dst_x1);
            dy1 = coord(r.dst_y1);
            dx2 = coord(r.dst_x2);
            dy2 = coord(r.dst_y2);
            cx1 = int'(r.clip_x1);
            cy1 = int'(r.clip_y1);
            cx2 = int'(r.clip_x2);
            cy2 = int'(r.clip_y2);
            span = dx2 - dx1 + 1;
            origin_x   = dx1;
            origin_y   = dy1;
            win_left   = ((dx1 > cx1) ? dx1 : cx1) - dx1;
            win_top    = ((dy1 > cy1) ? dy1 : cy1) - dy1;
            win_right  = ((dx2 < cx2) ? dx2 : cx2) - dx1;
            win_bottom = ((dy2 < cy2) ? dy2 : cy2) - dy1;
            row_stride = (span > 0) ? (span + 7) / 8 : 0;
            win_nonempty = (win_left <= win_right) && (win_top <= win_bottom)
                           && (row_stride != 0);
            cur_row      = 0;
            cur_byte_col = 0;
            draw_color   = r.fg_color;
            return 1'b1;
         end
         if (!win_nonempty) return 1'b0;
         if (cur_row >= win_top && cur_row <= win_bottom) begin
            found = 0;
            for (int k = 0; k < 8; k++) begin
               col = cur_byte_col * 8 + k;
               sx  = origin_x + col;
               sy  = origin_y + cur_row;
               if (r.bitmap_byte[7-k] && col >= win_left && col <= win_right &&
                   sx >= 0 && sx < FRAME_WIDTH && sy >= 0 && sy < FRAME_HEIGHT) begin
                  addr          = sy * FRAME_WIDTH + sx;
                  w.fb_addr     = addr[ADDR_BITS-1:0];
                  w.pixel_color = draw_color;
                  w.last        = 1'b0;
                  pending_writes.push_back(w);
                  found++;
               end
            end
            if (found > 0) pending_writes[pending_writes.size()-1].last = 1'b1;
         end
         cur_byte_col++;
         if (cur_byte_col >= row_stride) begin
            cur_byte_col = 0;
            // row counter saturates so a long stream never wraps back into the window
            if (cur_row < MAX_ROW) cur_row++;
         end
         return 1'b1;
      endfunction

      function void check_write(mbcb_rsp_type got);
         mbcb_rsp_type want;
         if (pending_writes.size() == 0) begin
            log_failure($sformatf("unexpected write: addr %0d color %06h last %0b",
                                  got.fb_addr, got.pixel_color, got.last));
            return;
         end
         want = pending_writes.pop_front();
         if (got.fb_addr !== want.fb_addr || got.pixel_color !== want.pixel_color ||
             got.last !== want.last)
            log_failure($sformatf(
               "write differs: expected addr %0d color %06h last %0b, got addr %0d color %06h last %0b",
               want.fb_addr, want.pixel_color, want.last,
               got.fb_addr, got.pixel_color, got.last));
      endfunction

      function void flag_leftovers();
         if (pending_writes.size() != 0) begin
            log_failure($sformatf("%0d writes never arrived, first addr %0d color %06h",
                                  pending_writes.size(), pending_writes[0].fb_addr,
                                  pending_writes[0].pixel_color));
            pending_writes.delete();
         end
      endfunction
   endclass

endpackage

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mbcb_pkg::*;
   import blit_check_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 16;
   localparam int TOTAL_ITEMS  = 110;
   localparam int CLIP_MAX     = (1 << CLIP_BITS) - 1;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   mbcb_req_type  req_data;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   mbcb_rsp_type  rsp_data;

   blit_scoreboard pixel_check = new();

   int cycle_count   = 0;
   int burst_left    = 0;
   int counted_items = 0;
   int ready_mode    = 0;
   int ready_phase   = 0;

   mono_bitmap_clip_blit_unit #(
      .FB_WIDTH  (FRAME_WIDTH),
      .FB_HEIGHT (FRAME_HEIGHT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: switches to a randomly chosen back-pressure pattern each time its phase counter runs out
   always @(negedge clock) begin
      if (ready_phase == 0) begin
         ready_mode  <= $urandom_range(0, 3);
         ready_phase <= 47;
      end else begin
         ready_phase <= ready_phase - 1;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ready_phase[0];
         2: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= (ready_phase[3:0] < 4);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) pixel_check.check_write(rsp_data);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mono_bitmap_clip_blit_unit: mismatch");
         $finish;
      end
   end

   function automatic mbcb_req_type random_req(logic req_kind);
      mbcb_req_type r;
      logic [31:0]  w0, w1, w2, w3;
      w0 = $urandom;
      w1 = $urandom;
      w2 = $urandom;
      w3 = $urandom;
      r.req_type    = req_kind;
      r.dst_x1      = w0[11:0];
      r.dst_y1      = w0[23:12];
      r.dst_x2      = w1[11:0];
      r.dst_y2      = w1[23:12];
      r.clip_x1     = w2[9:0];
      r.clip_y1     = w2[19:10];
      r.clip_x2     = w2[29:20];
      r.clip_y2     = w3[9:0];
      r.bitmap_byte = w3[17:10];
      r.fg_color    = {w0[31:24], w1[31:24], w3[31:24]};
      return r;
   endfunction

   function automatic logic [7:0] random_byte();
      logic [31:0] w;
      w = $urandom;
      case (w[10:8])
         0: return 8'hFF;
         1: return 8'h00;
         default: return w[7:0];
      endcase
   endfunction

   function automatic int clamp_clip(int v);
      return (v < 0) ? 0 : ((v > CLIP_MAX) ? CLIP_MAX : v);
   endfunction

   // sender: bursts of random length separated by random gaps
   task automatic push_request(input mbcb_req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      void'(pixel_check.note_request(r));
      counted_items++;
      @(negedge clock);
   endtask

   task automatic send_cmd(input int x1, y1, x2, y2, cx1, cy1, cx2, cy2,
                           input logic [COLOR_BITS-1:0] color);
      mbcb_req_type r;
      r = random_req(REQ_CMD);
      r.dst_x1   = 12'(x1);
      r.dst_y1   = 12'(y1);
      r.dst_x2   = 12'(x2);
      r.dst_y2   = 12'(y2);
      r.clip_x1  = 10'(cx1);
      r.clip_y1  = 10'(cy1);
      r.clip_x2  = 10'(cx2);
      r.clip_y2  = 10'(cy2);
      r.fg_color = color;
      push_request(r);
   endtask

   task automatic send_byte(input logic [7:0] b);
      mbcb_req_type r;
      r = random_req(REQ_BYTE);
      r.bitmap_byte = b;
      push_request(r);
   endtask

   // mostly a small blit with its full bitmap, sometimes a very wide one or a random command
   task automatic random_blit_run();
      int x1, y1, w, h, cx1, cy1, cx2, cy2, nbytes, pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         push_request(random_req(REQ_CMD));
         repeat ($urandom_range(0, 4)) push_request(random_req(REQ_BYTE));
      end else begin
         if (pick == 1) begin
            x1 = -int'($urandom_range(1, 64));
            w  = $urandom_range(2000, 2048 - x1);
            h  = $urandom_range(1, 2);
         end else begin
            x1 = $urandom_range(0, 660) - 30;
            w  = $urandom_range(1, 24);
            h  = $urandom_range(1, 5);
         end
         y1 = $urandom_range(0, 1060) - 30;
         if ($urandom_range(0, 1) == 0) begin
            cx1 = 0;
            cy1 = 0;
            cx2 = CLIP_MAX;
            cy2 = CLIP_MAX;
         end else begin
            cx1 = clamp_clip(x1 + $urandom_range(0, 6) - 4);
            cy1 = clamp_clip(y1 + $urandom_range(0, h + 2) - 2);
            cx2 = clamp_clip(cx1 + $urandom_range(0, 30) - 2);
            cy2 = clamp_clip(cy1 + $urandom_range(0, h + 2));
         end
         if (pick == 1) nbytes = (-x1) / 8 + $urandom_range(1, 12);
         else nbytes = ((w + 7) / 8) * h + $urandom_range(0, (w + 7) / 8);
         send_cmd(x1, y1, x1 + w - 1, y1 + h - 1, cx1, cy1, cx2, cy2, 24'($urandom));
         repeat (nbytes) send_byte(random_byte());
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // byte with no blit started yet
      send_byte(8'hFF);
      // window narrower than the destination, set bits outside it, row past the bottom
      send_cmd(100, 50, 115, 51, 104, 0, 111, CLIP_MAX, 24'hFFFFFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h0F);
      send_byte(8'hAA);
      // inverted destination
      send_cmd(2047, 2047, -2048, -2048, 0, 0, CLIP_MAX, CLIP_MAX, 24'h000000);
      send_byte(8'hFF);
      // destination and scissor do not overlap
      send_cmd(-2048, -2048, -2048, -2048, CLIP_MAX, CLIP_MAX, CLIP_MAX, CLIP_MAX, 24'h123456);
      send_byte(8'hFF);
      // origin above and left of the screen
      send_cmd(-5, -3, 10, 2, 0, 0, CLIP_MAX, CLIP_MAX, 24'h00FF00);
      repeat (6) send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h01);
      // scissor reaches past the framebuffer's right edge
      send_cmd(590, 1020, 605, 1023, 0, 1020, CLIP_MAX, CLIP_MAX, 24'hABCDEF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'h3F);

      // widest destination: 512-byte rows, first bytes lie left of the screen
      send_cmd(-2048, 0, 2047, 1, 0, 0, CLIP_MAX, CLIP_MAX, 24'hC0FFEE);
      repeat (4) send_byte(random_byte());

      while (counted_items < TOTAL_ITEMS) random_blit_run();
      req_valid <= 1'b0;

      while (pixel_check.pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      pixel_check.flag_leftovers();
      if (pixel_check.failures == 0) begin
         $display("mono_bitmap_clip_blit_unit: match");
      end else begin
         $display("mono_bitmap_clip_blit_unit: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/mbcb_pkg.sv
hdl/mbcb_decode.sv
hdl/mbcb_emit.sv
hdl/mono_bitmap_clip_blit_unit.sv
tb/blit_check_pkg.sv
tb/testbench.sv
